>>> rtl/core/direction_to_spherical_angles_assert.svh
// Assertion macros for the direction to spherical angles block.
`ifndef DIRECTION_TO_SPHERICAL_ANGLES_ASSERT_SVH
`define DIRECTION_TO_SPHERICAL_ANGLES_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dsa_pkg.sv
// Package: types, constants and table functions of the spherical angle pipeline.
package dsa_pkg;

  // Datapath configuration
  localparam int CORDIC_ITERATIONS = 16;
  localparam int FRACTION_BITS     = 14;
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS
                                                                    : ATAN_LEN;
  localparam int STEP_W            = 5;

  // Input format is Q1.14
  localparam int IN_W  = 16;
  localparam int IN_FB = 14;
  localparam int FB_UP = (FRACTION_BITS >= IN_FB) ? FRACTION_BITS - IN_FB : 0;
  localparam int FB_DN = (FRACTION_BITS <  IN_FB) ? IN_FB - FRACTION_BITS : 0;
  localparam logic signed [IN_W-1:0] Z_MAX = 16'sd16384;
  localparam logic signed [IN_W-1:0] Z_MIN = -16'sd16384;

  // Integer square root of the Q2.28 value 1 - z*z
  localparam int SQ_W      = 29;
  localparam int SQ_STEPS  = 15;
  localparam int SQ_STEP_W = 4;
  localparam int SQ_TOP    = SQ_W - 1;
  localparam int ROOT_W    = 15;
  localparam logic [SQ_W-1:0] SQ_ONE = 29'h1000_0000;

  // Angle widths
  localparam int DW = FRACTION_BITS + 5;  // signed CORDIC word
  localparam int AW = FRACTION_BITS + 3;  // non-negative angle below two pi
  localparam int MW = 27;                 // unit multiplier
  localparam int PW = AW + MW;
  localparam int CONV_SH = FRACTION_BITS + 13;
  localparam int RES_W   = 17;

  localparam logic [MW-1:0] MUL_RAD = 27'd67108864;
  localparam logic [MW-1:0] MUL_DEG = 27'd60078979;
  localparam logic [RES_W-1:0] FULL_RAD = 17'd51472;
  localparam logic [RES_W-1:0] FULL_DEG = 17'd46080;

  localparam int THETA_W = 15;
  localparam int PHI_W   = 16;

  // Q3.30 angle constants
  localparam longint PI_Q30         = 64'sd3373259426;
  localparam longint HALF_PI_Q30    = 64'sd1686629713;
  localparam longint THR_HALF_PI_Q30 = 64'sd5059889139;
  localparam longint TWO_PI_Q30     = 64'sd6746518852;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_ANGLE_UNIT = 1'b0;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef enum logic [1:0] {
    TH_CORDIC,
    TH_ZERO,
    TH_PI,
    TH_HALF
  } theta_sel_t;

  typedef enum logic [2:0] {
    PH_CORDIC,
    PH_UNDEF,
    PH_ZERO,
    PH_PI,
    PH_HALF,
    PH_THREE_HALF
  } phi_sel_t;

  typedef struct packed {
    logic signed [IN_W-1:0] zc;
    logic                   clamped;
    phi_sel_t               phi_sel;
    theta_sel_t             theta_sel;
  } side_t;

  typedef struct packed {
    logic [THETA_W-1:0] theta;
    logic [PHI_W-1:0]   phi;
    logic               undef;
    logic               clamped;
  } result_t;

  // Positive Q30 constant to the datapath format, rounded
  function automatic logic signed [DW-1:0] from_q30(input longint v);
    int     d;
    longint r;
    d = 30 - FRACTION_BITS;
    if (d <= 0) begin
      r = v;
    end else begin
      r = (v + (longint'(1) << (d - 1))) >>> d;
    end
    return r[DW-1:0];
  endfunction

  localparam logic signed [DW-1:0] ANGLE_PI       = from_q30(PI_Q30);
  localparam logic signed [DW-1:0] ANGLE_HALF     = from_q30(HALF_PI_Q30);
  localparam logic signed [DW-1:0] ANGLE_THR_HALF = from_q30(THR_HALF_PI_Q30);
  localparam logic signed [DW-1:0] ANGLE_TWO_PI   = from_q30(TWO_PI_Q30);

  // atan(2^-i) in Q2.30
  function automatic longint atan_q30(input logic [STEP_W-1:0] i);
    longint v;
    case (i)
      5'd0:    v = 64'sd843314857;
      5'd1:    v = 64'sd497837829;
      5'd2:    v = 64'sd263043836;
      5'd3:    v = 64'sd133525158;
      5'd4:    v = 64'sd67021686;
      5'd5:    v = 64'sd33543515;
      5'd6:    v = 64'sd16775850;
      5'd7:    v = 64'sd8388437;
      5'd8:    v = 64'sd4194282;
      5'd9:    v = 64'sd2097149;
      5'd10:   v = 64'sd1048576;
      5'd11:   v = 64'sd524288;
      5'd12:   v = 64'sd262144;
      5'd13:   v = 64'sd131072;
      5'd14:   v = 64'sd65536;
      5'd15:   v = 64'sd32768;
      5'd16:   v = 64'sd16384;
      5'd17:   v = 64'sd8192;
      5'd18:   v = 64'sd4096;
      5'd19:   v = 64'sd2048;
      5'd20:   v = 64'sd1024;
      5'd21:   v = 64'sd512;
      5'd22:   v = 64'sd256;
      5'd23:   v = 64'sd128;
      default: v = 64'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] atan_fb(input logic [STEP_W-1:0] i);
    return from_q30(atan_q30(i));
  endfunction

  // Q1.14 value to the datapath format
  function automatic logic signed [DW-1:0] to_fb(input logic signed [IN_W:0] v);
    logic signed [DW+IN_W:0] t;
    t = (DW + IN_W + 1)'(v);
    t = (t <<< FB_UP) >>> FB_DN;
    return t[DW-1:0];
  endfunction

  // Fold the left half plane onto the right one before vectoring
  function automatic cordic_t cordic_init(input logic signed [DW-1:0] x,
                                          input logic signed [DW-1:0] y);
    cordic_t c;
    if (x[DW-1]) begin
      c.x   = -x;
      c.y   = -y;
      c.acc = ANGLE_PI;
    end else begin
      c.x   = x;
      c.y   = y;
      c.acc = '0;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/dsa_sqrt_cell.sv
// One digit cell of the restoring integer square root chain.
module dsa_sqrt_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [dsa_pkg::SQ_STEP_W-1:0]    step,
  input  dsa_pkg::sqrt_t                   din,
  output dsa_pkg::sqrt_t                   dout
);

  logic [dsa_pkg::SQ_W-1:0] bitv;
  logic [dsa_pkg::SQ_W:0]   trial;
  dsa_pkg::sqrt_t           dout_next;

  always_comb begin
    // trial bit is 4^(top digit - step)
    bitv  = {{(dsa_pkg::SQ_W-1){1'b0}}, 1'b1} << (dsa_pkg::SQ_TOP - 2 * int'(step));
    trial = {1'b0, din.root} + {1'b0, bitv};
    if ({1'b0, din.rem} >= trial) begin
      dout_next.rem  = din.rem - trial[dsa_pkg::SQ_W-1:0];
      dout_next.root = (din.root >> 1) + bitv;
    end else begin
      dout_next.rem  = din.rem;
      dout_next.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/core/dsa_cordic_cell.sv
// One vectoring micro-rotation cell of a CORDIC chain.
module dsa_cordic_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dsa_pkg::STEP_W-1:0]    step,
  input  dsa_pkg::cordic_t              din,
  output dsa_pkg::cordic_t              dout
);

  logic signed [dsa_pkg::DW-1:0] xs;
  logic signed [dsa_pkg::DW-1:0] ys;
  logic signed [dsa_pkg::DW-1:0] ang;
  dsa_pkg::cordic_t              dout_next;

  always_comb begin
    xs  = din.x >>> step;
    ys  = din.y >>> step;
    ang = dsa_pkg::atan_fb(step);
    // rotate toward the x axis
    if (!din.y[dsa_pkg::DW-1]) begin
      dout_next.x   = din.x + ys;
      dout_next.y   = din.y - xs;
      dout_next.acc = din.acc + ang;
    end else begin
      dout_next.x   = din.x - ys;
      dout_next.y   = din.y + xs;
      dout_next.acc = din.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

>>> rtl/core/direction_to_spherical_angles.sv
// Top level: unit direction vector to polar and azimuth angles, pipelined.
//
//  channel   | signals                                  | role
//  ----------+------------------------------------------+------------------------------
//  dir       | dir_valid dir_stall dir_x dir_y dir_z    | one direction per transaction
//  angle     | angle_valid angle_stall theta_angle      | one result per transaction
//            | phi_angle phi_undefined z_clamped        |
//  apb       | psel penable pwrite paddr pwdata prdata  | angle_unit at byte address 0
//
//  One transaction per clock while dir_stall is low. A result passes the 15-cell
//  square root chain in series with the 16-cell theta CORDIC chain; the phi
//  CORDIC chain runs beside them.
//  rst is synchronous and clears the valid bits, the skid slot and angle_unit.
//  An output register plus one skid slot decouple the sides: dir_stall rises only
//  once the skid slot holds a result, and then the whole pipe holds.
`include "direction_to_spherical_angles_assert.svh"

module direction_to_spherical_angles (
  input  logic                                clk,
  input  logic                                rst,
  // direction input
  input  logic                                dir_valid,
  output logic                                dir_stall,
  input  logic signed [dsa_pkg::IN_W-1:0]     dir_x,
  input  logic signed [dsa_pkg::IN_W-1:0]     dir_y,
  input  logic signed [dsa_pkg::IN_W-1:0]     dir_z,
  // angle output
  output logic                                angle_valid,
  input  logic                                angle_stall,
  output logic [dsa_pkg::THETA_W-1:0]         theta_angle,
  output logic [dsa_pkg::PHI_W-1:0]           phi_angle,
  output logic                                phi_undefined,
  output logic                                z_clamped,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dsa_pkg::PADDR_W-1:0]         paddr,
  input  logic [dsa_pkg::PDATA_W-1:0]         pwdata,
  output logic [dsa_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  // Stage map: 0 input, 1 prep, root cells, theta init, theta cells, select, multiply
  localparam int SQ          = dsa_pkg::SQ_STEPS;
  localparam int C           = dsa_pkg::CORDIC_STEPS;
  localparam int S_SQRT_END  = 1 + SQ;
  localparam int S_TINIT     = S_SQRT_END + 1;
  localparam int S_TCORD_END = S_TINIT + C;
  localparam int S_SEL       = S_TCORD_END + 1;
  localparam int S_MUL       = S_SEL + 1;
  localparam int PH_DLY      = SQ + 1;  // phi chain finishes this many stages early
  localparam int DW          = dsa_pkg::DW;
  localparam int AW          = dsa_pkg::AW;
  localparam int PW          = dsa_pkg::PW;
  localparam logic [PW:0] CONV_RND = (PW + 1)'(1) << (dsa_pkg::CONV_SH - 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic angle_unit;
  logic reg_hit;

  assign reg_hit = (paddr[dsa_pkg::PADDR_W-1:2] == dsa_pkg::REG_ANGLE_UNIT);
  assign pready  = 1'b1;
  assign prdata  = (psel && reg_hit) ? {{(dsa_pkg::PDATA_W-1){1'b0}}, angle_unit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_unit <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      angle_unit <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control: the whole pipe moves unless the skid slot is occupied
  // ---------------------------------------------------------------------------
  logic         skid_valid;
  logic         en;
  logic [S_MUL:0] valid_q;

  assign en        = !skid_valid;
  assign dir_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[S_MUL-1:0], dir_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: take the transaction, saturate z
  // ---------------------------------------------------------------------------
  logic signed [dsa_pkg::IN_W-1:0] x0, y0, zc0;
  logic                            clamped0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= dir_x;
      y0 <= dir_y;
      if (dir_z > dsa_pkg::Z_MAX) begin
        zc0      <= dsa_pkg::Z_MAX;
        clamped0 <= 1'b1;
      end else if (dir_z < dsa_pkg::Z_MIN) begin
        zc0      <= dsa_pkg::Z_MIN;
        clamped0 <= 1'b1;
      end else begin
        zc0      <= dir_z;
        clamped0 <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: 1 - z*z for the root chain, phi fold and axis classification
  // ---------------------------------------------------------------------------
  logic signed [2*dsa_pkg::IN_W-1:0] zz;
  dsa_pkg::phi_sel_t                 phi_sel_next;
  dsa_pkg::sqrt_t                    sq_in;
  dsa_pkg::cordic_t                  ph_in;
  dsa_pkg::side_t                    side_q [1:S_TCORD_END];

  assign zz = zc0 * zc0;

  always_comb begin
    if (x0 == '0 && y0 == '0) begin
      phi_sel_next = dsa_pkg::PH_UNDEF;
    end else if (y0 == '0) begin
      phi_sel_next = x0[dsa_pkg::IN_W-1] ? dsa_pkg::PH_PI : dsa_pkg::PH_ZERO;
    end else if (x0 == '0) begin
      phi_sel_next = y0[dsa_pkg::IN_W-1] ? dsa_pkg::PH_THREE_HALF : dsa_pkg::PH_HALF;
    end else begin
      phi_sel_next = dsa_pkg::PH_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in.rem            <= dsa_pkg::SQ_ONE - zz[dsa_pkg::SQ_W-1:0];
      sq_in.root           <= '0;
      ph_in                <= dsa_pkg::cordic_init(dsa_pkg::to_fb(17'(x0)),
                                                   dsa_pkg::to_fb(17'(y0)));
      side_q[1].zc         <= zc0;
      side_q[1].clamped    <= clamped0;
      side_q[1].phi_sel    <= phi_sel_next;
      side_q[1].theta_sel  <= dsa_pkg::TH_CORDIC;
    end
  end

  // ---------------------------------------------------------------------------
  // Root chain, one result bit per cell, beside the phi CORDIC chain
  // ---------------------------------------------------------------------------
  dsa_pkg::sqrt_t   sq_q [SQ];
  dsa_pkg::cordic_t ph_q [C];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    dsa_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (dsa_pkg::SQ_STEP_W'(k)),
      .din  ((k == 0) ? sq_in : sq_q[(k == 0) ? 0 : k - 1]),
      .dout (sq_q[k])
    );
  end

  for (genvar j = 0; j < C; j++) begin : g_phi
    dsa_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (dsa_pkg::STEP_W'(j)),
      .din  ((j == 0) ? ph_in : ph_q[(j == 0) ? 0 : j - 1]),
      .dout (ph_q[j])
    );
  end

  // Phi angle waits for theta
  logic signed [DW-1:0] ph_dly [PH_DLY];

  for (genvar d = 0; d < PH_DLY; d++) begin : g_ph_dly
    always_ff @(posedge clk) begin
      if (en) begin
        ph_dly[d] <= (d == 0) ? ph_q[C-1].acc : ph_dly[(d == 0) ? 0 : d - 1];
      end
    end
  end

  // Sideband shift line; theta class is filled in at theta init
  logic [dsa_pkg::ROOT_W-1:0] s_root;
  dsa_pkg::theta_sel_t        theta_sel_next;
  dsa_pkg::cordic_t           th_in;
  logic signed [dsa_pkg::IN_W-1:0] zc_t;

  assign s_root = sq_q[SQ-1].root[dsa_pkg::ROOT_W-1:0];
  assign zc_t   = side_q[S_TINIT-1].zc;

  always_comb begin
    if (s_root == '0) begin
      theta_sel_next = zc_t[dsa_pkg::IN_W-1] ? dsa_pkg::TH_PI : dsa_pkg::TH_ZERO;
    end else if (zc_t == '0) begin
      theta_sel_next = dsa_pkg::TH_HALF;
    end else begin
      theta_sel_next = dsa_pkg::TH_CORDIC;
    end
  end

  for (genvar s = 2; s <= S_TCORD_END; s++) begin : g_side
    dsa_pkg::side_t side_in;

    always_comb begin
      side_in = side_q[s-1];
      if (s == S_TINIT) begin
        side_in.theta_sel = theta_sel_next;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Theta init and theta CORDIC chain: atan2(sqrt(1 - z*z), z)
  // ---------------------------------------------------------------------------
  dsa_pkg::cordic_t th_q [C];

  always_ff @(posedge clk) begin
    if (en) begin
      th_in <= dsa_pkg::cordic_init(dsa_pkg::to_fb(17'(zc_t)),
                                    dsa_pkg::to_fb({2'b00, s_root}));
    end
  end

  for (genvar j = 0; j < C; j++) begin : g_theta
    dsa_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (dsa_pkg::STEP_W'(j)),
      .din  ((j == 0) ? th_in : th_q[(j == 0) ? 0 : j - 1]),
      .dout (th_q[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Select: axis cases, theta clamp to [0, pi], phi wrap into [0, 2pi)
  // ---------------------------------------------------------------------------
  dsa_pkg::side_t       side_e;
  logic signed [DW-1:0] th_acc, ph_acc, th_sel, ph_sel;
  logic [AW-1:0]        sel_theta, sel_phi;
  logic                 sel_undef, sel_clamped;

  assign side_e = side_q[S_TCORD_END];
  assign th_acc = th_q[C-1].acc;
  assign ph_acc = ph_dly[PH_DLY-1];

  always_comb begin
    case (side_e.theta_sel)
      dsa_pkg::TH_ZERO: th_sel = '0;
      dsa_pkg::TH_PI:   th_sel = dsa_pkg::ANGLE_PI;
      dsa_pkg::TH_HALF: th_sel = dsa_pkg::ANGLE_HALF;
      default: begin
        if (th_acc[DW-1]) begin
          th_sel = '0;
        end else if (th_acc > dsa_pkg::ANGLE_PI) begin
          th_sel = dsa_pkg::ANGLE_PI;
        end else begin
          th_sel = th_acc;
        end
      end
    endcase

    case (side_e.phi_sel)
      dsa_pkg::PH_UNDEF,
      dsa_pkg::PH_ZERO:       ph_sel = '0;
      dsa_pkg::PH_PI:         ph_sel = dsa_pkg::ANGLE_PI;
      dsa_pkg::PH_HALF:       ph_sel = dsa_pkg::ANGLE_HALF;
      dsa_pkg::PH_THREE_HALF: ph_sel = dsa_pkg::ANGLE_THR_HALF;
      default: begin
        if (ph_acc[DW-1]) begin
          ph_sel = ph_acc + dsa_pkg::ANGLE_TWO_PI;
        end else if (ph_acc >= dsa_pkg::ANGLE_TWO_PI) begin
          ph_sel = ph_acc - dsa_pkg::ANGLE_TWO_PI;
        end else begin
          ph_sel = ph_acc;
        end
        if (ph_sel[DW-1]) begin
          ph_sel = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_theta   <= th_sel[AW-1:0];
      sel_phi     <= ph_sel[AW-1:0];
      sel_undef   <= (side_e.phi_sel == dsa_pkg::PH_UNDEF);
      sel_clamped <= side_e.clamped;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply by the unit scale
  // ---------------------------------------------------------------------------
  logic [dsa_pkg::MW-1:0] unit_mul;
  logic [PW-1:0]          mul_theta, mul_phi;
  logic                   mul_undef, mul_clamped;

  assign unit_mul = angle_unit ? dsa_pkg::MUL_DEG : dsa_pkg::MUL_RAD;

  always_ff @(posedge clk) begin
    if (en) begin
      mul_theta   <= PW'(sel_theta) * PW'(unit_mul);
      mul_phi     <= PW'(sel_phi) * PW'(unit_mul);
      mul_undef   <= sel_undef;
      mul_clamped <= sel_clamped;
    end
  end

  // ---------------------------------------------------------------------------
  // Round half up, full turn reads as zero
  // ---------------------------------------------------------------------------
  logic [PW:0]               rnd_theta, rnd_phi;
  logic [dsa_pkg::RES_W-1:0] phi_full, phi_round;
  dsa_pkg::result_t          res, skid;

  assign rnd_theta = {1'b0, mul_theta} + CONV_RND;
  assign rnd_phi   = {1'b0, mul_phi} + CONV_RND;
  assign phi_full  = angle_unit ? dsa_pkg::FULL_DEG : dsa_pkg::FULL_RAD;
  assign phi_round = rnd_phi[dsa_pkg::CONV_SH +: dsa_pkg::RES_W];

  always_comb begin
    res.theta   = rnd_theta[dsa_pkg::CONV_SH +: dsa_pkg::THETA_W];
    res.phi     = (phi_round >= phi_full) ? '0 : phi_round[dsa_pkg::PHI_W-1:0];
    res.undef   = mul_undef;
    res.clamped = mul_clamped;
  end

  // ---------------------------------------------------------------------------
  // Output register and skid slot
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!angle_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (valid_q[S_MUL]) begin
      if (!angle_valid || !angle_stall) begin
        angle_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (!angle_stall) begin
      angle_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!angle_stall) begin
        {theta_angle, phi_angle, phi_undefined, z_clamped} <= skid;
      end
    end else if (valid_q[S_MUL]) begin
      if (!angle_valid || !angle_stall) begin
        {theta_angle, phi_angle, phi_undefined, z_clamped} <= res;
      end else begin
        skid <= res;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DSA_ASSERT_IMP(a_skid_behind_out, skid_valid, angle_valid, "skid full with no output")
  `DSA_ASSERT_NEXT(a_stalled_result_to_skid,
                   angle_valid && angle_stall && !skid_valid && valid_q[S_MUL],
                   skid_valid, "stalled result not parked in skid")
  `DSA_ASSERT_IMP(a_phi_below_full,
                  angle_valid,
                  (!angle_unit && phi_angle < dsa_pkg::FULL_RAD) ||
                  (angle_unit && phi_angle < dsa_pkg::FULL_DEG),
                  "phi reached a full turn")
  `DSA_ASSERT_IMP(a_undef_phi_zero, angle_valid && phi_undefined, phi_angle == '0,
                  "undefined azimuth with nonzero phi")

endmodule
